FILE: design/cfud_pkg.sv
package cfud_pkg;

    // Fixed field widths of the frame format
    localparam int BYTE_W        = 8;
    localparam int ID_W          = 16;
    localparam int LEN_W         = 4;
    localparam int PAYLOAD_BYTES = 8;
    localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_BYTES);

    // Defaults handed to the top level
    localparam int MAX_PAYLOAD_DEFAULT = 8;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;

    // Reset values of the markers
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;

    // Parser phase of the front part
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_ID_HI = 3'd1,
        PH_ID_LO = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5,
        PH_END   = 3'd6
    } phase_t;

    // Operations passed from the front part to the back part
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_ID_HI = 3'd1,
        OP_ID_LO = 3'd2,
        OP_LEN   = 3'd3,
        OP_DATA  = 3'd4,
        OP_EMIT  = 3'd5
    } op_t;

    // One queued request: operation and its byte
    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
    } req_t;

endpackage

FILE: design/cfud_front.sv
module cfud_front
    import cfud_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] start_marker,
    input  logic [BYTE_W-1:0] end_marker,
    output logic              push,
    output req_t              push_req
);

    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   cnt_inc;

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            xor_reg   <= '0;
            cnt_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
        end
    end

    assign cnt_inc = cnt_reg + LEN_W'(1);

    // Classify the byte and advance the phase
    always_comb
    begin
        phase_next    = phase_reg;
        xor_next      = xor_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        push          = 1'b0;
        push_req.op   = OP_START;
        push_req.data = rx_byte;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_ID_HI:
                begin
                    xor_next    = xor_reg ^ rx_byte;
                    push        = 1'b1;
                    push_req.op = OP_ID_HI;
                    phase_next  = PH_ID_LO;
                end
                PH_ID_LO:
                begin
                    xor_next    = xor_reg ^ rx_byte;
                    push        = 1'b1;
                    push_req.op = OP_ID_LO;
                    phase_next  = PH_LEN;
                end
                PH_LEN:
                begin
                    xor_next = xor_reg ^ rx_byte;
                    if (rx_byte <= BYTE_W'(MAX_PAYLOAD))
                    begin
                        len_next    = rx_byte[LEN_W-1:0];
                        push        = 1'b1;
                        push_req.op = OP_LEN;
                        phase_next  = (rx_byte == '0) ? PH_CHECK : PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    xor_next    = xor_reg ^ rx_byte;
                    cnt_next    = cnt_inc;
                    push        = 1'b1;
                    push_req.op = OP_DATA;
                    if (cnt_inc >= len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = (rx_byte == xor_reg) ? PH_END : PH_HUNT;
                end
                PH_END:
                begin
                    phase_next = PH_HUNT;
                    if (rx_byte == end_marker)
                    begin
                        push        = 1'b1;
                        push_req.op = OP_EMIT;
                    end
                end
                default:
                begin
                    // Hunting, and any unused phase code
                    phase_next = PH_HUNT;
                    if (rx_byte == start_marker)
                    begin
                        phase_next  = PH_ID_HI;
                        xor_next    = '0;
                        cnt_next    = '0;
                        len_next    = '0;
                        push        = 1'b1;
                        push_req.op = OP_START;
                    end
                end
            endcase
        end
    end

`ifndef SYNTH
    a_data_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (cnt_reg < len_reg))
        else $error("payload count reached length while still in data phase");

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg <= LEN_W'(MAX_PAYLOAD)))
        else $error("held length above maximum payload");
`endif

endmodule

FILE: design/cfud_queue.sv
module cfud_queue
    import cfud_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_req,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output req_t head_req
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    req_t              mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push_fire, pop_fire;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign push_fire = push && !full;
    assign pop_fire  = pop && not_empty;
    assign head_req  = mem[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Hold pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(DEPTH)))
        else $error("queue fill count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && !pop_fire) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue fill count did not grow on push");
`endif

endmodule

FILE: design/cfud_back.sv
module cfud_back
    import cfud_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  req_t              head_req,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ID_W-1:0]   frame_id,
    output logic [LEN_W-1:0]  payload_len,
    output logic [BYTE_W-1:0] payload [PAYLOAD_BYTES]
);

    logic [ID_W-1:0]          id_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [BYTE_W-1:0]        data_reg [PAYLOAD_BYTES];
    logic [PAYLOAD_IDX_W-1:0] idx_reg;
    logic                     out_valid_reg;
    logic [ID_W-1:0]          out_id_reg;
    logic [LEN_W-1:0]         out_len_reg;
    logic [BYTE_W-1:0]        out_data_reg [PAYLOAD_BYTES];
    logic                     out_free;
    logic                     emit;

    // Take a request unless it emits and the output is still occupied
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = q_not_empty && ((head_req.op != OP_EMIT) || out_free);
    assign emit     = pop && (head_req.op == OP_EMIT);

    // Build the frame from the queued requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg  <= '0;
            len_reg <= '0;
            idx_reg <= '0;
            for (int i = 0; i < PAYLOAD_BYTES; i++)
            begin
                data_reg[i] <= '0;
            end
        end
        else if (pop)
        begin
            unique case (head_req.op)
                OP_START:
                begin
                    id_reg  <= '0;
                    len_reg <= '0;
                    idx_reg <= '0;
                    for (int i = 0; i < PAYLOAD_BYTES; i++)
                    begin
                        data_reg[i] <= '0;
                    end
                end
                OP_ID_HI: id_reg <= {head_req.data, {(ID_W - BYTE_W){1'b0}}};
                OP_ID_LO: id_reg[BYTE_W-1:0] <= head_req.data;
                OP_LEN:   len_reg <= head_req.data[LEN_W-1:0];
                OP_DATA:
                begin
                    data_reg[idx_reg] <= head_req.data;
                    idx_reg           <= idx_reg + PAYLOAD_IDX_W'(1);
                end
                OP_EMIT:  ;
                default:  ;
            endcase
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_id_reg   <= id_reg;
            out_len_reg  <= len_reg;
            out_data_reg <= data_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_id    = out_id_reg;
    assign payload_len = out_len_reg;
    assign payload     = out_data_reg;

`ifndef SYNTH
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emitted frame not presented");

    a_drop_only_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(!out_stall))
        else $error("result withdrawn while stalled");
`endif

endmodule

FILE: design/can_frame_uart_deframer.sv
// Byte-stream deframer: start marker, 16-bit id (high byte first), length,
// payload, XOR checksum, end marker.
//
// Input channel: rx_byte with in_valid/in_stall, one byte per request.
// Output channel: frame_id, payload_len and payload_b0..payload_b7 with
// out_valid/out_stall; unused payload bytes read as zero.
// Configuration: cfg_we, cfg_index, cfg_data; index 0 is the start marker,
// index 1 the end marker; other indexes are ignored.
//
// Throughput: one byte per cycle while in_stall is low. A front parser
// classifies each byte and pushes an operation into a four-entry queue; a
// back part owns the output register and applies one operation per cycle
// unless an emit waits for that register to be free. A frame's emit passes
// through the queue before it loads the output register.
// Stall: while out_stall holds a result, operations that do not emit keep
// draining; in_stall rises only when the queue fills.
// Reset: markers return to 0xAA and 0x55, the parser hunts for a start
// marker, the queue empties and no result is pending.
module can_frame_uart_deframer
    import cfud_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ID_W-1:0]      frame_id,
    output logic [LEN_W-1:0]     payload_len,
    output logic [BYTE_W-1:0]    payload_b0,
    output logic [BYTE_W-1:0]    payload_b1,
    output logic [BYTE_W-1:0]    payload_b2,
    output logic [BYTE_W-1:0]    payload_b3,
    output logic [BYTE_W-1:0]    payload_b4,
    output logic [BYTE_W-1:0]    payload_b5,
    output logic [BYTE_W-1:0]    payload_b6,
    output logic [BYTE_W-1:0]    payload_b7
);

    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] end_marker_reg;
    logic              in_fire;
    logic              push;
    req_t              push_req;
    logic              q_full;
    logic              q_not_empty;
    req_t              head_req;
    logic              pop;
    logic [BYTE_W-1:0] payload [PAYLOAD_BYTES];

    // Hold the marker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_START_MARKER)
            begin
                start_marker_reg <= cfg_data;
            end
            else if (cfg_index == CFG_END_MARKER)
            begin
                end_marker_reg <= cfg_data;
            end
        end
    end

    assign in_stall = q_full;
    assign in_fire  = in_valid && !in_stall;

    cfud_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .rx_byte      (rx_byte),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .push         (push),
        .push_req     (push_req)
    );

    cfud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_req  (head_req)
    );

    cfud_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head_req    (head_req),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_id    (frame_id),
        .payload_len (payload_len),
        .payload     (payload)
    );

    assign payload_b0 = payload[0];
    assign payload_b1 = payload[1];
    assign payload_b2 = payload[2];
    assign payload_b3 = payload[3];
    assign payload_b4 = payload[4];
    assign payload_b5 = payload[5];
    assign payload_b6 = payload[6];
    assign payload_b7 = payload[7];

endmodule

FILE: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cfud_pkg::*;

    localparam int MAX_LEN      = MAX_PAYLOAD_DEFAULT;
    localparam int DRAIN_CYCLES = QUEUE_DEPTH_DEFAULT + 4;
    localparam int HANG_LIMIT   = 2000;
    localparam int PHASE_BYTES  = 175;

    // Indexes past the register list; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]                       id;
        logic [LEN_W-1:0]                      len;
        logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0]  pay;
    } frame_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              typed;
        frame_t            want;
    } dir_row_t;

    localparam frame_t NO_FRAME       = '0;
    localparam frame_t ZERO_LEN_FRAME = '{id: 16'hAA55, len: 4'd0, pay: '0};
    localparam frame_t FULL_FRAME     = '{id: 16'hFFFF, len: 4'd8, pay: '1};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ID_W-1:0]      frame_id;
    logic [LEN_W-1:0]     payload_len;
    logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] got_pay;

    // Predictor state and its copy of the markers
    phase_t                               rx_phase = PH_HUNT;
    logic [ID_W-1:0]                      held_id = '0;
    logic [LEN_W-1:0]                     held_len = '0;
    logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] held_pay = '0;
    logic [3:0]                           held_cnt = '0;
    logic [BYTE_W-1:0]                    run_xor = '0;
    logic [BYTE_W-1:0]                    start_mk = START_MARKER_RST;
    logic [BYTE_W-1:0]                    end_mk = END_MARKER_RST;

    frame_t frames_due [$];
    bit     quiet = 1'b0;
    int     errors = 0;
    int     bytes_sent = 0;
    int     frames_seen = 0;
    int     settings_used = 1;
    int     hang_cycles = 0;

    // Directed frames under the reset markers
    dir_row_t directed_rows [36] = '{
        // noise while hunting
        '{8'h00, 1'b0, NO_FRAME},
        // zero length, start marker reused as id high byte
        '{8'hAA, 1'b0, NO_FRAME}, '{8'hAA, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME},
        '{8'h00, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'h55, 1'b1, ZERO_LEN_FRAME},
        // full length, all ones
        '{8'hAA, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'h08, 1'b0, NO_FRAME},
        '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'h08, 1'b0, NO_FRAME}, '{8'h55, 1'b1, FULL_FRAME},
        // checksum mismatch
        '{8'hAA, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
        '{8'h00, 1'b0, NO_FRAME}, '{8'h01, 1'b0, NO_FRAME},
        // wrong end byte
        '{8'hAA, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
        '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h54, 1'b0, NO_FRAME},
        // length above the maximum
        '{8'hAA, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
        '{8'h09, 1'b0, NO_FRAME}
    };

    can_frame_uart_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_id    (frame_id),
        .payload_len (payload_len),
        .payload_b0  (got_pay[0]),
        .payload_b1  (got_pay[1]),
        .payload_b2  (got_pay[2]),
        .payload_b3  (got_pay[3]),
        .payload_b4  (got_pay[4]),
        .payload_b5  (got_pay[5]),
        .payload_b6  (got_pay[6]),
        .payload_b7  (got_pay[7])
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the deframer by one byte; return 1 with the frame when it completes
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output frame_t f);
        bit hit;
        hit = 1'b0;
        f = NO_FRAME;
        case (rx_phase)
            PH_ID_HI:
            begin
                held_id = {b, 8'h00};
                run_xor ^= b;
                rx_phase = PH_ID_LO;
            end
            PH_ID_LO:
            begin
                held_id[7:0] = b;
                run_xor ^= b;
                rx_phase = PH_LEN;
            end
            PH_LEN:
            begin
                run_xor ^= b;
                if (b <= MAX_LEN)
                begin
                    held_len = b[LEN_W-1:0];
                    rx_phase = (b == 8'h00) ? PH_CHECK : PH_DATA;
                end
                else
                    rx_phase = PH_HUNT;
            end
            PH_DATA:
            begin
                held_pay[held_cnt[2:0]] = b;
                run_xor ^= b;
                held_cnt = held_cnt + 4'd1;
                if (held_cnt >= held_len)
                    rx_phase = PH_CHECK;
            end
            PH_CHECK:
                rx_phase = (b == run_xor) ? PH_END : PH_HUNT;
            PH_END:
            begin
                rx_phase = PH_HUNT;
                if (b == end_mk)
                begin
                    f.id = held_id;
                    f.len = held_len;
                    f.pay = held_pay;
                    hit = 1'b1;
                end
            end
            default:
            begin
                rx_phase = PH_HUNT;
                if (b == start_mk)
                begin
                    rx_phase = PH_ID_HI;
                    run_xor = '0;
                    held_cnt = '0;
                    held_id = '0;
                    held_len = '0;
                    held_pay = '0;
                end
            end
        endcase
        return hit;
    endfunction

    // Offer one byte, wait for the request to be taken, then predict
    task automatic send_byte(input logic [BYTE_W-1:0] b, output bit emitted);
        frame_t f;
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        emitted = deframe_byte(b, f);
        if (emitted)
            frames_due.push_back(f);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every frame due, then let the queue drain
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (frames_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        if (idx == CFG_START_MARKER)
            start_mk = d;
        else if (idx == CFG_END_MARKER)
            end_mk = d;
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Build one frame under the current markers, mostly well formed
    task automatic send_random_frame();
        logic [BYTE_W-1:0] burst [$];
        logic [BYTE_W-1:0] chk;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] pb;
        logic [ID_W-1:0]   id;
        int                kind;
        int                cut;
        bit                dummy;
        burst = {};
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 4))
                burst.push_back(8'($urandom));
        kind = $urandom_range(0, 99);
        id   = 16'($urandom);
        len  = (kind >= 70 && kind < 78) ? 8'($urandom_range(MAX_LEN + 1, 255))
                                         : 8'($urandom_range(0, MAX_LEN));
        burst.push_back(start_mk);
        burst.push_back(id[15:8]);
        burst.push_back(id[7:0]);
        burst.push_back(len);
        chk = id[15:8] ^ id[7:0] ^ len;
        if (kind >= 70 && kind < 78)
        begin
            // bad length: trailing bytes should be hunted over
            repeat ($urandom_range(0, 3))
                burst.push_back(8'($urandom));
        end
        else
        begin
            repeat (len)
            begin
                pb = 8'($urandom);
                burst.push_back(pb);
                chk ^= pb;
            end
            if (kind >= 78 && kind < 86)
                chk ^= 8'($urandom_range(1, 255));
            burst.push_back(chk);
            if (kind >= 86 && kind < 93)
                burst.push_back(end_mk ^ 8'($urandom_range(1, 255)));
            else
                burst.push_back(end_mk);
            // truncate: the next start marker lands inside this frame
            if (kind >= 93)
            begin
                cut = $urandom_range(1, burst.size() - 1);
                burst = burst[0:cut-1];
            end
        end
        foreach (burst[i])
            send_byte(burst[i], dummy);
    endtask

    // Random back-pressure on the result channel
    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 7);

    // Compare each accepted frame with the oldest one due
    always @(posedge clk)
    begin
        frame_t want;
        int     k;
        if (rst_n && out_valid && !out_stall)
        begin
            frames_seen++;
            if (frames_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected frame id %h len %0d", $time, frame_id, payload_len);
            end
            else
            begin
                want = frames_due.pop_front();
                if (frame_id !== want.id)
                begin
                    errors++;
                    $display("%0t: frame_id expected %h got %h", $time, want.id, frame_id);
                end
                if (payload_len !== want.len)
                begin
                    errors++;
                    $display("%0t: payload_len expected %0d got %0d",
                             $time, want.len, payload_len);
                end
                for (k = 0; k < PAYLOAD_BYTES; k++)
                    if (got_pay[k] !== want.pay[k])
                    begin
                        errors++;
                        $display("%0t: payload_b%0d expected %h got %h",
                                 $time, k, want.pay[k], got_pay[k]);
                    end
            end
        end
    end

    // Hang detection: count cycles with no request moving on any port
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d frames outstanding",
                     $time, HANG_LIMIT, frames_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        bit                emitted;
        int                p;
        int                phase_end;
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] e;

        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Writes past the register list must leave the reset markers alone
        cfg_write(CFG_SPARE_A, 8'h00);
        cfg_write(CFG_SPARE_B, 8'hFF);

        // Directed table: typed frames override the prediction where given
        foreach (directed_rows[r])
        begin
            send_byte(directed_rows[r].rx, emitted);
            if (directed_rows[r].typed)
            begin
                if (emitted)
                    frames_due[frames_due.size() - 1] = directed_rows[r].want;
                else
                    frames_due.push_back(directed_rows[r].want);
            end
        end

        // Random phases; the first and last run under the reset markers, the others under a pair written here
        for (p = 0; p < 8; p++)
        begin
            settle();
            if (p > 0)
            begin
                case (p)
                    1:       {s, e} = {8'h00, 8'hFF};
                    2:       {s, e} = {8'hFF, 8'h00};
                    4:       {s, e} = {8'h7E, 8'h7E};
                    6:       {s, e} = {8'h01, 8'h80};
                    7:       {s, e} = {START_MARKER_RST, END_MARKER_RST};
                    default: {s, e} = {8'($urandom), 8'($urandom)};
                endcase
                cfg_write(CFG_START_MARKER, s);
                cfg_write(CFG_END_MARKER, e);
                settings_used++;
            end
            quiet = (p == 3);
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                send_random_frame();
        end
        quiet = 1'b0;
        settle();

        $display("Summary: %0d bytes sent, %0d frames checked under %0d marker settings",
                 bytes_sent, frames_seen, settings_used);
        $display("Summary: bad lengths, checksums, end bytes, truncations and noise covered");
        if (errors == 0 && frames_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/cfud_pkg.sv
design/cfud_front.sv
design/cfud_queue.sv
design/cfud_back.sv
design/can_frame_uart_deframer.sv
verif/testbench.sv
